@@ hdl/rs485ev_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485ev_pkg
// Shared types and codes of the RS485 echo-verified transmit controller.
// ----------------------------------------------------------------------------
package rs485ev_pkg;

    localparam int POS_W  = 8;
    localparam int BYTE_W = 8;
    localparam int FUNC_W = 4;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD          = 4'd0,
        FN_SEND          = 4'd1,
        FN_RX_EDGE       = 4'd2,
        FN_RX_EVENT      = 4'd3,
        FN_TX_READY      = 4'd4,
        FN_TX_DONE       = 4'd5,
        FN_FRAME_TIMEOUT = 4'd6,
        FN_IDLE_TIMEOUT  = 4'd7,
        FN_TICK          = 4'd8,
        FN_CLEAR_RESULT  = 4'd9
    } t_func;

    localparam logic [STAT_W-1:0] ST_PENDING  = 3'd0;
    localparam logic [STAT_W-1:0] ST_OK       = 3'd1;
    localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_LINE_ERR = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd4;

    // Write and read request to the transmit store.
    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [POS_W-1:0]  raddr;
    } t_store_req;

endpackage

@@ hdl/rs485ev_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485ev_store
// Transmit byte store: one write port, one registered read port with
// write-to-read forwarding; positions beyond the store read as zero.
// ----------------------------------------------------------------------------
module rs485ev_store
    import rs485ev_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [BYTE_W-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              w_in_range;
    logic              r_in_range;

    assign w_in_range = ({1'b0, i_req.waddr} < (POS_W+1)'(DEPTH));
    assign r_in_range = ({1'b0, i_req.raddr} < (POS_W+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_req.we && w_in_range) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // A load committed at the same edge must be seen by the read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (!r_in_range) begin
                r_rdata <= '0;
            end else if (i_req.we && (i_req.waddr == i_req.raddr)) begin
                r_rdata <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.raddr[AW-1:0]];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rs485_echo_verified_transmit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_echo_verified_transmit
// Half-duplex RS485 transmit controller with echo verification of sent bytes.
//
//  Channel  | Direction | tuser      | tdata
//  s_axis   | in        | func [3:0] | load_index, data_byte, send_count, flags
//  m_axis   | out       | -          | one status/result word per request
//
// Each request is held in the input register before it moves to the result
// register, from which its result is offered; one request is taken every cycle
// unless the result register stalls. The store read for a request is launched as
// it is accepted, from the positions that the request ahead of it leaves behind.
// A stalled result register holds the input register and all state.
// Reset (i_rst_n low, synchronous) clears control state; store is not cleared.
// ----------------------------------------------------------------------------
module rs485_echo_verified_transmit
    import rs485ev_pkg::*;
#(
    parameter int TX_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] load_index, [15:8] data_byte, [23:16] send_count,
    // [24] rx_has_error, [25] rx_has_data, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    // [3:0] func
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] tx_byte_valid, [8:1] tx_byte, [9] rx_pass_valid, [17:10] rx_pass_byte,
    // [18] frame_discard, [19] restart_rx_timer, [20] driver_enable,
    // [21] edge_watch, [22] tx_request_enable, [25:23] send_status,
    // [26] line_busy, [27] receiving, [31:28] zero
    output logic [31:0] m_axis_tdata
);

    // Input register
    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [POS_W-1:0]  r_load_index;
    logic [BYTE_W-1:0] r_data_byte;
    logic [POS_W-1:0]  r_send_count;
    logic              r_has_err;
    logic              r_has_data;

    // Controller state
    logic [POS_W-1:0]  r_tx_length, n_tx_length;
    logic [POS_W-1:0]  r_send_pos, n_send_pos;
    logic [POS_W-1:0]  r_echo_pos, n_echo_pos;
    logic              r_transmitting, n_transmitting;
    logic              r_rx_busy, n_rx_busy;
    logic              r_not_idle, n_not_idle;
    logic [STAT_W-1:0] r_result, n_result;
    logic              r_finished, n_finished;
    logic              r_deferred, n_deferred;
    logic              r_edge_on, n_edge_on;
    logic              r_driver_on, n_driver_on;
    logic              r_tx_irq_on, n_tx_irq_on;

    // Result register
    logic              r_out_valid;
    logic [31:0]       r_out_data, n_out_data;

    logic              w_adv;
    logic              w_accept;
    logic [BYTE_W-1:0] w_rdata;
    t_store_req        w_req;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Read address comes from the positions after the request now in flight.
    always_comb begin
        w_req.we    = w_adv && (r_func == FN_LOAD);
        w_req.waddr = r_load_index;
        w_req.wdata = r_data_byte;
        w_req.re    = w_accept;
        w_req.raddr = (s_axis_tuser == FN_TX_READY) ? n_send_pos : n_echo_pos;
    end

    rs485ev_store #(
        .DEPTH (TX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    always_comb begin
        logic              txv;
        logic              rxv;
        logic              discard;
        logic              restart;
        logic [BYTE_W-1:0] txb;
        logic [BYTE_W-1:0] rxb;
        txv            = 1'b0;
        rxv            = 1'b0;
        discard        = 1'b0;
        restart        = 1'b0;
        txb            = '0;
        rxb            = '0;
        n_tx_length    = r_tx_length;
        n_send_pos     = r_send_pos;
        n_echo_pos     = r_echo_pos;
        n_transmitting = r_transmitting;
        n_rx_busy      = r_rx_busy;
        n_not_idle     = r_not_idle;
        n_result       = r_result;
        n_finished     = r_finished;
        n_deferred     = r_deferred;
        n_edge_on      = r_edge_on;
        n_driver_on    = r_driver_on;
        n_tx_irq_on    = r_tx_irq_on;
        if (w_adv) begin
            case (r_func)
                FN_LOAD: begin
                    // Store write is issued through w_req.
                end
                FN_SEND: begin
                    n_tx_length = r_send_count;
                    n_send_pos  = '0;
                    n_echo_pos  = '0;
                    n_result    = ST_PENDING;
                    n_finished  = 1'b0;
                    if (!r_not_idle) begin
                        n_edge_on   = 1'b0;
                        n_driver_on = 1'b1;
                        n_tx_irq_on = 1'b1;
                    end else begin
                        n_deferred = 1'b1;
                    end
                end
                FN_RX_EDGE: begin
                    if (r_edge_on) begin
                        if (!r_transmitting) begin
                            restart    = 1'b1;
                            n_rx_busy  = 1'b1;
                            n_not_idle = 1'b1;
                        end
                        n_edge_on = 1'b0;
                    end
                end
                FN_RX_EVENT: begin
                    if (!r_transmitting) begin
                        restart    = 1'b1;
                        n_rx_busy  = 1'b1;
                        n_not_idle = 1'b1;
                    end
                    // A line error ends the send before the data is looked at.
                    if (r_has_err && r_transmitting) begin
                        n_result       = ST_LINE_ERR;
                        n_transmitting = 1'b0;
                        n_edge_on      = 1'b1;
                    end
                    if (r_has_data) begin
                        if (n_transmitting) begin
                            n_echo_pos = r_echo_pos + 1'b1;
                            if (r_data_byte != w_rdata) begin
                                n_result       = ST_MISMATCH;
                                n_transmitting = 1'b0;
                                n_edge_on      = 1'b1;
                            end else if (n_echo_pos == r_tx_length) begin
                                n_result       = ST_OK;
                                n_transmitting = 1'b0;
                                n_edge_on      = 1'b1;
                            end
                        end else begin
                            rxv = 1'b1;
                            rxb = r_data_byte;
                        end
                    end
                end
                FN_TX_READY: begin
                    if (r_tx_irq_on) begin
                        n_transmitting = 1'b1;
                        if (r_send_pos < r_tx_length) begin
                            txv        = 1'b1;
                            txb        = w_rdata;
                            n_send_pos = r_send_pos + 1'b1;
                        end else begin
                            n_tx_irq_on = 1'b0;
                        end
                    end
                end
                FN_TX_DONE: begin
                    n_driver_on = 1'b0;
                    if (r_transmitting) begin
                        n_result       = ST_TIMEOUT;
                        n_transmitting = 1'b0;
                        n_edge_on      = 1'b1;
                    end
                end
                FN_FRAME_TIMEOUT: begin
                    discard   = 1'b1;
                    n_rx_busy = 1'b0;
                    n_edge_on = 1'b1;
                end
                FN_IDLE_TIMEOUT: begin
                    n_not_idle = 1'b0;
                    if (r_deferred) begin
                        n_edge_on   = 1'b0;
                        n_driver_on = 1'b1;
                        n_tx_irq_on = 1'b1;
                        n_deferred  = 1'b0;
                    end
                end
                FN_TICK: begin
                    if (!r_finished && (r_result != ST_PENDING)) begin
                        n_finished     = 1'b1;
                        n_transmitting = 1'b0;
                        n_edge_on      = 1'b1;
                    end
                end
                FN_CLEAR_RESULT: begin
                    n_result = ST_PENDING;
                end
                default: begin
                end
            endcase
        end
        n_out_data = {4'b0, n_rx_busy, n_not_idle, n_result, n_tx_irq_on, n_edge_on,
                      n_driver_on, restart, discard, rxb, rxv, txb, txv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tx_length    <= '0;
            r_send_pos     <= '0;
            r_echo_pos     <= '0;
            r_transmitting <= 1'b0;
            r_rx_busy      <= 1'b0;
            r_not_idle     <= 1'b0;
            r_result       <= ST_PENDING;
            r_finished     <= 1'b1;
            r_deferred     <= 1'b0;
            r_edge_on      <= 1'b1;
            r_driver_on    <= 1'b0;
            r_tx_irq_on    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_tx_length    <= n_tx_length;
            r_send_pos     <= n_send_pos;
            r_echo_pos     <= n_echo_pos;
            r_transmitting <= n_transmitting;
            r_rx_busy      <= n_rx_busy;
            r_not_idle     <= n_not_idle;
            r_result       <= n_result;
            r_finished     <= n_finished;
            r_deferred     <= n_deferred;
            r_edge_on      <= n_edge_on;
            r_driver_on    <= n_driver_on;
            r_tx_irq_on    <= n_tx_irq_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func       <= s_axis_tuser;
            r_load_index <= s_axis_tdata[7:0];
            r_data_byte  <= s_axis_tdata[15:8];
            r_send_count <= s_axis_tdata[23:16];
            r_has_err    <= s_axis_tdata[24];
            r_has_data   <= s_axis_tdata[25];
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An empty result register never holds back the input side.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // Every request that leaves the input register lands in the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed request produced no result");

    // A byte is only handed out while transmitter-ready events stay enabled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> r_out_data[22])
        else $error("tx byte issued with transmitter requests disabled");

    // The send status is always a defined code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[25:23] <= ST_MISMATCH))
        else $error("undefined send status");

endmodule

@@ tb/rs485_echo_verified_transmit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_echo_verified_transmit_test
// Self-checking bench for the echo-verified RS485 transmit controller. Line
// events go in over the request stream. An in-bench predictor of the
// controller works out the status word that each event should produce, and
// every word leaving the block is compared field by field with the oldest
// prediction. A short directed pass covers the corner cases. After it come
// random frames (load, send, ready, echo, done) and noise, under four mixes
// of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module rs485_echo_verified_transmit_test;
    import rs485ev_pkg::*;

    localparam int unsigned RANDOM_EVENTS = 104;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned STORE_SLOTS   = 256;
    localparam int unsigned BURST_LOADS   = 8;
    localparam logic [FUNC_W-1:0] FN_TOP  = '1;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  load_index;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  send_count;
        logic              rx_has_error;
        logic              rx_has_data;
    } t_line_event;

    typedef struct {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              discard;
        logic              restart;
        logic              drive;
        logic              watch;
        logic              req_enable;
        logic [STAT_W-1:0] status;
        logic              busy;
        logic              receiving;
    } t_status_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] load_index, [15:8] data_byte, [23:16] send_count,
    // [24] rx_has_error, [25] rx_has_data, [31:26] zero
    logic [31:0] s_axis_tdata = '0;
    // [3:0] func
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] tx_byte_valid, [8:1] tx_byte, [9] rx_pass_valid, [17:10] rx_pass_byte,
    // [18] frame_discard, [19] restart_rx_timer, [20] driver_enable,
    // [21] edge_watch, [22] tx_request_enable, [25:23] send_status,
    // [26] line_busy, [27] receiving, [31:28] zero
    logic [31:0] m_axis_tdata;

    // Predicted state of the controller.
    logic [BYTE_W-1:0] store_img [STORE_SLOTS];
    bit                store_written [STORE_SLOTS];
    logic [POS_W-1:0]  frame_len, tx_pos, echo_idx;
    logic [STAT_W-1:0] send_code;
    bit xmit, rx_in_progress, line_active, done_flag, send_waiting, edge_en, drv_en, ready_en;

    t_status_word status_words_due [$];
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned events_accepted = 0;
    int unsigned words_checked = 0;
    int unsigned frames_run = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    rs485_echo_verified_transmit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Controller predictor
    // ------------------------------------------------------------------
    function automatic void clear_controller_state();
        frame_len      = '0;
        tx_pos         = '0;
        echo_idx       = '0;
        send_code      = ST_PENDING;
        xmit           = 1'b0;
        rx_in_progress = 1'b0;
        line_active    = 1'b0;
        done_flag      = 1'b1;
        send_waiting   = 1'b0;
        edge_en        = 1'b1;
        drv_en         = 1'b0;
        ready_en       = 1'b0;
    endfunction

    function automatic void end_send(input logic [STAT_W-1:0] code);
        send_code = code;
        xmit      = 1'b0;
        edge_en   = 1'b1;
    endfunction

    function automatic void start_line();
        edge_en  = 1'b0;
        drv_en   = 1'b1;
        ready_en = 1'b1;
    endfunction

    function automatic t_status_word advance_controller(input t_line_event ev);
        t_status_word w;
        logic [BYTE_W-1:0] sent;
        w = '{default: '0};
        case (ev.func)
            FN_LOAD: begin
                store_img[ev.load_index]     = ev.data_byte;
                store_written[ev.load_index] = 1'b1;
            end
            FN_SEND: begin
                frame_len = ev.send_count;
                tx_pos    = '0;
                echo_idx  = '0;
                send_code = ST_PENDING;
                done_flag = 1'b0;
                if (!line_active) start_line();
                else send_waiting = 1'b1;
            end
            FN_RX_EDGE: begin
                if (edge_en) begin
                    if (!xmit) begin
                        w.restart      = 1'b1;
                        rx_in_progress = 1'b1;
                        line_active    = 1'b1;
                    end
                    edge_en = 1'b0;
                end
            end
            FN_RX_EVENT: begin
                if (!xmit) begin
                    w.restart      = 1'b1;
                    rx_in_progress = 1'b1;
                    line_active    = 1'b1;
                end
                // A line error closes the send first; any data then counts as
                // ordinary received data.
                if (ev.rx_has_error && xmit) end_send(ST_LINE_ERR);
                if (ev.rx_has_data) begin
                    if (xmit) begin
                        sent     = store_img[echo_idx];
                        echo_idx = echo_idx + 1'b1;
                        if (ev.data_byte != sent) end_send(ST_MISMATCH);
                        else if (echo_idx == frame_len) end_send(ST_OK);
                    end else begin
                        w.rx_valid = 1'b1;
                        w.rx_byte  = ev.data_byte;
                    end
                end
            end
            FN_TX_READY: begin
                if (ready_en) begin
                    xmit = 1'b1;
                    if (tx_pos < frame_len) begin
                        w.tx_valid = 1'b1;
                        w.tx_byte  = store_img[tx_pos];
                        tx_pos     = tx_pos + 1'b1;
                    end else begin
                        ready_en = 1'b0;
                    end
                end
            end
            FN_TX_DONE: begin
                drv_en = 1'b0;
                if (xmit) end_send(ST_TIMEOUT);
            end
            FN_FRAME_TIMEOUT: begin
                w.discard      = 1'b1;
                rx_in_progress = 1'b0;
                edge_en        = 1'b1;
            end
            FN_IDLE_TIMEOUT: begin
                line_active = 1'b0;
                if (send_waiting) begin
                    start_line();
                    send_waiting = 1'b0;
                end
            end
            FN_TICK: begin
                if (!done_flag && send_code != ST_PENDING) begin
                    done_flag = 1'b1;
                    xmit      = 1'b0;
                    edge_en   = 1'b1;
                end
            end
            FN_CLEAR_RESULT: send_code = ST_PENDING;
            default: ;
        endcase
        w.drive      = drv_en;
        w.watch      = edge_en;
        w.req_enable = ready_en;
        w.status     = send_code;
        w.busy       = line_active;
        w.receiving  = rx_in_progress;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic t_line_event mk_event(input logic [FUNC_W-1:0] f,
                                             input logic [7:0] idx, input logic [7:0] data,
                                             input logic [7:0] cnt, input bit err,
                                             input bit has_data);
        t_line_event ev;
        ev.func         = f;
        ev.load_index   = idx;
        ev.data_byte    = data;
        ev.send_count   = cnt;
        ev.rx_has_error = err;
        ev.rx_has_data  = has_data;
        return ev;
    endfunction

    function automatic t_line_event random_fields(input logic [FUNC_W-1:0] f);
        return mk_event(f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
    endfunction

    task automatic offer_event(input t_line_event ev);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ev.rx_has_data, ev.rx_has_error, ev.send_count,
                          ev.data_byte, ev.load_index};
        s_axis_tuser  <= ev.func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        status_words_due.push_back(advance_controller(ev));
        events_accepted++;
    endtask

    task automatic ensure_loaded(input logic [POS_W-1:0] pos);
        t_line_event ev;
        if (!store_written[pos]) begin
            ev = random_fields(FN_LOAD);
            ev.load_index = pos;
            offer_event(ev);
        end
    endtask

    // Any request that would read a never-loaded store entry gets a load
    // of that entry in front of it.
    task automatic put_event(input t_line_event ev);
        if (ev.func == FN_TX_READY && ready_en && tx_pos < frame_len)
            ensure_loaded(tx_pos);
        else if (ev.func == FN_RX_EVENT && xmit && ev.rx_has_data && !ev.rx_has_error)
            ensure_loaded(echo_idx);
        offer_event(ev);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (status_words_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_status_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_words_due.size() == 0) begin
                $error("status word %h arrived with no request waiting", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = status_words_due.pop_front();
                words_checked++;
                compare_field("tx_byte_valid", 8'(want.tx_valid), 8'(m_axis_tdata[0]));
                compare_field("tx_byte", want.tx_byte, m_axis_tdata[8:1]);
                compare_field("rx_pass_valid", 8'(want.rx_valid), 8'(m_axis_tdata[9]));
                compare_field("rx_pass_byte", want.rx_byte, m_axis_tdata[17:10]);
                compare_field("frame_discard", 8'(want.discard), 8'(m_axis_tdata[18]));
                compare_field("restart_rx_timer", 8'(want.restart), 8'(m_axis_tdata[19]));
                compare_field("driver_enable", 8'(want.drive), 8'(m_axis_tdata[20]));
                compare_field("edge_watch", 8'(want.watch), 8'(m_axis_tdata[21]));
                compare_field("tx_request_enable", 8'(want.req_enable),
                              8'(m_axis_tdata[22]));
                compare_field("send_status", 8'(want.status), 8'(m_axis_tdata[25:23]));
                compare_field("line_busy", 8'(want.busy), 8'(m_axis_tdata[26]));
                compare_field("receiving", 8'(want.receiving), 8'(m_axis_tdata[27]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d status words outstanding",
                     cycle_count, status_words_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_levels();
        put_event(mk_event(FN_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        // Codes above clear_result must leave everything as it is.
        put_event(mk_event(FN_TOP, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    endtask

    task automatic test_receive_path();
        put_event(mk_event(FN_RX_EVENT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        put_event(mk_event(FN_RX_EVENT, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0));
        put_event(mk_event(FN_RX_EDGE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        // The watch is already off, so a repeated edge is ignored.
        put_event(mk_event(FN_RX_EDGE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_FRAME_TIMEOUT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_echo_send();
        put_event(mk_event(FN_LOAD, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_LOAD, 8'h01, 8'hA5, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_LOAD, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
        // The line is still busy from the receive test, so the send waits.
        put_event(mk_event(FN_SEND, 8'h00, 8'h00, 8'h02, 1'b0, 1'b0));
        put_event(mk_event(FN_IDLE_TIMEOUT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        repeat (4) put_event(mk_event(FN_TX_READY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_RX_EVENT, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1));
        put_event(mk_event(FN_RX_EVENT, 8'h00, 8'hA5, 8'h00, 1'b1, 1'b1));
        put_event(mk_event(FN_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_CLEAR_RESULT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_send_timeout();
        put_event(mk_event(FN_SEND, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0));
        put_event(mk_event(FN_IDLE_TIMEOUT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_TX_READY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        put_event(mk_event(FN_TX_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic echo_step(input bit full_wrap);
        t_line_event ev;
        int unsigned pick;
        int unsigned flip;
        pick = full_wrap ? 0 : $urandom_range(99);
        if (pick >= 96) return;    // echo lost on the line
        ensure_loaded(echo_idx);
        ev = random_fields(FN_RX_EVENT);
        ev.data_byte    = store_img[echo_idx];
        ev.rx_has_error = 1'b0;
        ev.rx_has_data  = 1'b1;
        if (pick >= 90) begin
            ev.rx_has_error = 1'b1;
            ev.rx_has_data  = 1'($urandom_range(1));
        end else if (pick >= 82) begin
            flip = $urandom_range(BYTE_W - 1);
            ev.data_byte[flip] = ~ev.data_byte[flip];
        end
        put_event(ev);
    endtask

    // One send from loading to the end of the line turn. Echoes trail the
    // ready requests by one byte. A zero-length send with a full wrap keeps
    // echoing until the echo position comes back round to zero.
    task automatic run_frame(input int unsigned n, input bit full_wrap);
        t_line_event ev;
        int unsigned i;
        int unsigned stop;
        for (i = 0; i < n && i < BURST_LOADS; i++) begin
            ev = random_fields(FN_LOAD);
            ev.load_index = POS_W'(i);
            put_event(ev);
        end
        if ($urandom_range(3) == 0) begin
            ev = random_fields(FN_RX_EVENT);
            ev.rx_has_error = 1'b0;
            ev.rx_has_data  = 1'b1;
            put_event(ev);
        end
        ev = random_fields(FN_SEND);
        ev.send_count = POS_W'(n);
        put_event(ev);
        if (send_waiting) put_event(random_fields(FN_IDLE_TIMEOUT));
        stop = full_wrap ? STORE_SLOTS : (n > 12 ? $urandom_range(12, 1) : n);
        for (i = 0; i <= stop; i++) begin
            if (ready_en) put_event(random_fields(FN_TX_READY));
            if (i > 0) begin
                if (!xmit) break;
                echo_step(full_wrap);
                if (!full_wrap && $urandom_range(49) == 0) begin
                    ev = random_fields(FN_SEND);
                    ev.send_count = POS_W'(n);
                    put_event(ev);
                end
            end
        end
        if ($urandom_range(3) == 0) put_event(random_fields(FN_TICK));
        put_event(random_fields(FN_TX_DONE));
        if ($urandom_range(1) == 0) put_event(random_fields(FN_TICK));
        if ($urandom_range(2) == 0) put_event(random_fields(FN_CLEAR_RESULT));
        if ($urandom_range(2) == 0) put_event(random_fields(FN_FRAME_TIMEOUT));
        if ($urandom_range(2) != 0) put_event(random_fields(FN_IDLE_TIMEOUT));
        frames_run++;
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned target;
        int unsigned midpoint;
        int unsigned size_pick;
        bit drained;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 77; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 77; end
                default: begin send_gap_pct = 8; recv_stall_pct = 8; end
            endcase
            if (phase == 0) run_frame(0, 1'b1);
            target   = events_accepted + RANDOM_EVENTS / 4;
            midpoint = events_accepted + RANDOM_EVENTS / 8;
            drained  = 1'b0;
            while (events_accepted < target) begin
                if (!drained && events_accepted >= midpoint) begin
                    hold_until_drained();
                    drained = 1'b1;
                end
                if ($urandom_range(9) < 7) begin
                    size_pick = $urandom_range(9);
                    if (size_pick == 0) run_frame(0, 1'b0);
                    else if (size_pick == 1) run_frame($urandom_range(255, 9), 1'b0);
                    else run_frame($urandom_range(BURST_LOADS, 1), 1'b0);
                end else begin
                    repeat ($urandom_range(4, 1))
                        put_event(random_fields(FUNC_W'($urandom_range(FN_TOP, FN_LOAD))));
                end
            end
        end
    endtask

    initial begin
        clear_controller_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_levels();
        test_receive_path();
        test_echo_send();
        test_send_timeout();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (status_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d line events over %0d frames and four gap/stall mixes", events_accepted,
                 frames_run);
        $display("%0d status words compared, %0d field mismatches", words_checked,
                 mismatch_count);
        if (mismatch_count == 0 && status_words_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
